### rtl/core/jtdp_pkg.sv
package jtdp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FTYPE = 3'd1,
    PH_FNAME = 3'd2,
    PH_MTYPE = 3'd3,
    PH_MNAME = 3'd4,
    PH_DRAIN = 3'd5
  } phase_e;

  localparam logic [3:0] KIND_OBJECT = 4'd8;
  localparam logic [3:0] KIND_END    = 4'd9;

  localparam logic [2:0] ERR_OK      = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN = 3'd1;
  localparam logic [2:0] ERR_UNTERM  = 3'd2;
  localparam logic [2:0] ERR_NOCOMP  = 3'd3;
  localparam logic [2:0] ERR_DIMS    = 3'd4;

  localparam logic [7:0] CH_OBJECT = 8'h4C;  // 'L'
  localparam logic [7:0] CH_ARRAY  = 8'h5B;  // '['
  localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'

  localparam logic [2:0] REG_SIGNATURE_MODE = 3'd0;

  typedef logic [7:0] base_letters_t [8];
  localparam base_letters_t BASE_LETTERS = '{
    8'h42, 8'h43, 8'h44, 8'h46, 8'h49, 8'h4A, 8'h53, 8'h5A  // B C D F I J S Z
  };

  typedef struct packed {
    logic [3:0]  type_kind;
    logic [7:0]  array_dims;
    logic [15:0] name_start;
    logic [15:0] name_length;
    logic [2:0]  error_code;
    logic        final_res;
  } res_t;

  // Map a base type letter to its kind code; hit is low for anything else.
  function automatic logic [3:0] base_kind(input logic [7:0] ch, output logic hit);
    logic [3:0] kind;
    kind = 4'd0;
    hit  = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (ch == BASE_LETTERS[i]) begin
        kind = 4'(i);
        hit  = 1'b1;
      end
    end
    return kind;
  endfunction

endpackage

### rtl/core/jtdp_if.sv
interface jtdp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;

  modport source (output valid, character, last_char, input ready);
  modport sink   (input valid, character, last_char, output ready);
endinterface

interface jtdp_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  type_kind;
  logic [7:0]  array_dims;
  logic [15:0] name_start;
  logic [15:0] name_length;
  logic [2:0]  error_code;
  logic        final_res;

  modport source (output valid, type_kind, array_dims, name_start, name_length,
                  error_code, final_res, input ready);
  modport sink   (input valid, type_kind, array_dims, name_start, name_length,
                  error_code, final_res, output ready);
endinterface

### rtl/core/jtdp_cfg_regs.sv
module jtdp_cfg_regs
  import jtdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        signature_mode_o
);

  logic mode_q, mode_d;
  logic hit;

  // Decode on the word address; byte offset bits are ignored.
  assign hit    = (paddr[2] == REG_SIGNATURE_MODE[2]);
  assign pready = 1'b1;

  always_comb begin
    mode_d = mode_q;
    if (psel && penable && pwrite && hit) begin
      mode_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign prdata           = hit ? {31'b0, mode_q} : 32'b0;
  assign signature_mode_o = mode_q;

endmodule

### rtl/core/jtdp_parse.sv
module jtdp_parse
  import jtdp_pkg::*;
#(
  parameter int unsigned MAX_CHARS = 65535,
  parameter int unsigned MAX_DIMS  = 255
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic signature_mode_i,
  jtdp_char_if.sink  ch_i,
  jtdp_res_if.source res_o
);

  localparam logic [15:0] PosMax  = 16'(MAX_CHARS);
  localparam logic [7:0]  DimsMax = 8'(MAX_DIMS);

  // Input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_char_q;
  logic       in_last_q;

  // Parser state
  phase_e      phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  dims_q, dims_d;
  logic [15:0] cstart_q, cstart_d;

  // Result register
  logic out_vld_q, out_vld_d;
  res_t out_q;

  logic adv;
  logic emit;
  res_t res;

  assign adv        = in_vld_q && (!out_vld_q || res_o.ready);
  assign ch_i.ready = !in_vld_q || adv;

  always_comb begin
    logic       meth;
    logic       done;
    logic       skip;
    logic       hit;
    logic [3:0] kind;
    logic [15:0] pos_inc;
    phase_e     ph;

    pos_inc  = (pos_q < PosMax) ? pos_q + 16'd1 : PosMax;
    phase_d  = phase_q;
    pos_d    = pos_inc;
    dims_d   = dims_q;
    cstart_d = cstart_q;
    emit     = 1'b0;
    done     = 1'b0;
    skip     = 1'b0;
    meth     = 1'b0;
    ph       = phase_q;
    res      = '{type_kind: KIND_END, array_dims: 8'd0, name_start: 16'd0,
                 name_length: 16'd0, error_code: ERR_OK, final_res: 1'b1};
    kind     = base_kind(in_char_q, hit);

    if (phase_q == PH_DRAIN) begin
      // drop characters until the end mark
      if (in_last_q) begin
        phase_d = PH_IDLE;
        pos_d   = 16'd0;
      end
    end else begin
      if (!(ph == PH_FTYPE || ph == PH_FNAME || ph == PH_MTYPE || ph == PH_MNAME)) begin
        dims_d   = 8'd0;
        cstart_d = 16'd0;
        if (signature_mode_i) begin
          ph   = PH_MTYPE;
          skip = 1'b1;
          if (in_last_q) begin
            emit = 1'b1;
            done = 1'b1;
          end
        end else begin
          ph = PH_FTYPE;
        end
      end

      meth = (ph == PH_MTYPE || ph == PH_MNAME);

      if (!skip) begin
        case (ph)
          PH_FTYPE, PH_MTYPE: begin
            if (meth && in_char_q == CH_RPAREN) begin
              emit           = 1'b1;
              done           = 1'b1;
              res.error_code = (dims_d != 8'd0) ? ERR_NOCOMP : ERR_OK;
            end else if (hit) begin
              emit           = 1'b1;
              res.type_kind  = kind;
              res.array_dims = dims_d;
              res.final_res  = !meth || in_last_q;
              done           = !meth || in_last_q;
              dims_d         = 8'd0;
            end else if (in_char_q == CH_OBJECT) begin
              cstart_d = pos_inc;
              ph       = meth ? PH_MNAME : PH_FNAME;
              if (in_last_q) begin
                emit           = 1'b1;
                done           = 1'b1;
                res.error_code = ERR_UNTERM;
              end
            end else if (in_char_q == CH_ARRAY) begin
              if (dims_d >= DimsMax) begin
                emit           = 1'b1;
                done           = 1'b1;
                res.error_code = ERR_DIMS;
              end else begin
                dims_d = dims_d + 8'd1;
                if (in_last_q) begin
                  emit           = 1'b1;
                  done           = 1'b1;
                  res.error_code = ERR_NOCOMP;
                end
              end
            end else begin
              emit           = 1'b1;
              done           = 1'b1;
              res.error_code = ERR_UNKNOWN;
            end
          end
          PH_FNAME, PH_MNAME: begin
            if (in_char_q == CH_SEMI) begin
              emit            = 1'b1;
              res.type_kind   = KIND_OBJECT;
              res.array_dims  = dims_d;
              res.name_start  = cstart_d;
              res.name_length = pos_q - cstart_d;
              res.final_res   = !meth || in_last_q;
              done            = !meth || in_last_q;
              dims_d          = 8'd0;
              ph              = meth ? PH_MTYPE : PH_FTYPE;
            end else if ((meth && in_char_q == CH_RPAREN) || in_last_q) begin
              emit           = 1'b1;
              done           = 1'b1;
              res.error_code = ERR_UNTERM;
            end
          end
          default: begin
          end
        endcase
      end

      if (done || in_last_q) begin
        ph       = in_last_q ? PH_IDLE : PH_DRAIN;
        dims_d   = 8'd0;
        cstart_d = 16'd0;
        if (in_last_q) begin
          pos_d = 16'd0;
        end
      end
      phase_d = ph;
    end
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (ch_i.valid && ch_i.ready) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv && emit) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= PH_IDLE;
      pos_q     <= 16'd0;
      dims_q    <= 8'd0;
      cstart_q  <= 16'd0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        phase_q  <= phase_d;
        pos_q    <= pos_d;
        dims_q   <= dims_d;
        cstart_q <= cstart_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ch_i.valid && ch_i.ready) begin
      in_char_q <= ch_i.character;
      in_last_q <= ch_i.last_char;
    end
    if (adv && emit) begin
      out_q <= res;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.type_kind   = out_q.type_kind;
  assign res_o.array_dims  = out_q.array_dims;
  assign res_o.name_start  = out_q.name_start;
  assign res_o.name_length = out_q.name_length;
  assign res_o.error_code  = out_q.error_code;
  assign res_o.final_res   = out_q.final_res;

endmodule

### rtl/core/jvm_type_descriptor_parser.sv
// Channel   Dir  Transaction                       Payload
// ch_i      in   one descriptor character          character, last_char
// res_o     out  one parsed type or status         type_kind, array_dims, name_start,
//                                                  name_length, error_code, final_res
// apb       in   register access (signature_mode)  paddr, pwdata, prdata
//
// One character per cycle sustained while res_o is not stalled: each character
// is held in the input register, is decoded against the parser state, and its
// result (if any) is registered in the result register, which drives res_o.
// Reset (rst_ni low, asynchronous) returns the parser to idle, position zero and
// signature_mode zero. A stalled res_o holds the result register; the input
// register then holds its character and ch_i.ready drops until the result is taken.
module jvm_type_descriptor_parser
  import jtdp_pkg::*;
#(
  parameter int unsigned MAX_CHARS = 65535,
  parameter int unsigned MAX_DIMS  = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  jtdp_char_if.sink   ch_i,
  jtdp_res_if.source  res_o
);

  logic signature_mode;

  // Mode register; sampled by the parser on the first character of a descriptor.
  jtdp_cfg_regs u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .signature_mode_o (signature_mode)
  );

  // Input register, per-character decode and result register.
  jtdp_parse #(
    .MAX_CHARS (MAX_CHARS),
    .MAX_DIMS  (MAX_DIMS)
  ) u_parse (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .signature_mode_i (signature_mode),
    .ch_i             (ch_i),
    .res_o            (res_o)
  );

endmodule
